// File: rtl/swa_pkg.sv
// Shared types and constants for the sliding window average pool.
// Used by every module of the block except swa_ram; depends on nothing.
`timescale 1ns / 1ps

package swa_pkg;

   // Sample and window geometry
   localparam int SAMPLE_BITS      = 16;
   localparam int WINDOW           = 5;
   localparam int LINES            = WINDOW - 1;          // power of two: row slot is low bits
   localparam int LINE_BITS        = $clog2(LINES);
   localparam int MAX_SIDE_DEFAULT = 32;

   // Configuration register
   localparam int                   SIDE_BITS  = 6;
   localparam logic [SIDE_BITS-1:0] SIDE_RESET = 6'd19;

   // Sum widths: one column of WINDOW samples, then WINDOW columns
   localparam int CSUM_BITS  = 19;
   localparam int TOTAL_BITS = 21;
   localparam int MAG_BITS   = 20;

   // Divide by WINDOW*WINDOW with rounding, through a reciprocal
   localparam int DEN         = WINDOW * WINDOW;
   localparam int HALF_DEN    = DEN / 2;
   localparam int RECIP_SHIFT = 24;
   localparam int RECIP_BITS  = 20;
   localparam int RECIP       = (1 << RECIP_SHIFT) / DEN;
   localparam int QUOT_BITS   = 16;

   // Result fields
   localparam int POS_BITS = 5;

   // Result queue
   localparam int RSP_DEPTH      = 8;
   localparam int RSP_PTR_BITS   = $clog2(RSP_DEPTH);
   localparam int RSP_COUNT_BITS = RSP_PTR_BITS + 1;

   // Per-transaction control carried down the pipeline
   typedef struct packed {
      logic                produce;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] col;
      logic                frame_end;
   } tag_type;

   // One finished result
   typedef struct packed {
      logic [SAMPLE_BITS-1:0] mean;
      logic [POS_BITS-1:0]    row;
      logic [POS_BITS-1:0]    col;
      logic                   frame_end;
   } rsp_type;

endpackage

// File: rtl/swa_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module swa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write, then register the read word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/swa_front.sv
// Front end: frame counters, line store read-modify-write and running column sums.
// Depends on swa_pkg and swa_ram.
`timescale 1ns / 1ps

module swa_front #(
   parameter int MAX_SIDE = swa_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         cfg_write,
   input  logic [swa_pkg::SIDE_BITS-1:0]                cfg_side,
   input  logic                                         accept,
   input  logic [swa_pkg::SAMPLE_BITS-1:0]              sample,
   output logic                                         sums_valid,
   output swa_pkg::tag_type                             sums_tag,
   output logic [swa_pkg::WINDOW-1:0][swa_pkg::CSUM_BITS-1:0] col_sums
);

   import swa_pkg::*;

   localparam int CNT_BITS  = $clog2(MAX_SIDE);
   localparam int EFF_BITS  = CNT_BITS + 1;
   localparam int WORD_BITS = LINES * SAMPLE_BITS;

   function automatic logic [EFF_BITS-1:0] clamp_side(input logic [SIDE_BITS-1:0] side);
      logic [EFF_BITS-1:0] eff;
      if (int'(side) < WINDOW) begin
         eff = EFF_BITS'(WINDOW);
      end else if (int'(side) > MAX_SIDE) begin
         eff = EFF_BITS'(MAX_SIDE);
      end else begin
         eff = EFF_BITS'(side);
      end
      return eff;
   endfunction

   logic [EFF_BITS-1:0]  side_ff, side_in;
   logic [CNT_BITS-1:0]  row_ff, row_in;
   logic [CNT_BITS-1:0]  col_ff, col_in;
   logic                 last_col, last_row;
   tag_type              tag_s0;

   logic                 s1_valid_ff;
   logic [SAMPLE_BITS-1:0] s1_sample_ff;
   logic [CNT_BITS-1:0]  s1_col_ff;
   logic [LINE_BITS-1:0] s1_slot_ff;
   logic                 s1_full_ff;
   tag_type              s1_tag_ff;

   logic [WORD_BITS-1:0] rd_word, wr_word;
   logic signed [CSUM_BITS-1:0] upper_sum, csum;

   logic                 s2_valid_ff;
   tag_type              s2_tag_ff;
   logic [WINDOW-1:0][CSUM_BITS-1:0] col_sums_ff;

   // Position of the current transaction in the frame
   assign last_col = ({1'b0, col_ff} == side_ff - 1'b1);
   assign last_row = ({1'b0, row_ff} == side_ff - 1'b1);

   always_comb begin
      tag_s0.produce   = (row_ff >= CNT_BITS'(LINES)) && (col_ff >= CNT_BITS'(LINES));
      tag_s0.row       = POS_BITS'(row_ff - CNT_BITS'(LINES));
      tag_s0.col       = POS_BITS'(col_ff - CNT_BITS'(LINES));
      tag_s0.frame_end = last_row && last_col;
   end

   // Advance counters; a side write restarts the frame
   always_comb begin
      side_in = side_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cfg_write) begin
         side_in = clamp_side(cfg_side);
         row_in  = '0;
         col_in  = '0;
      end else if (accept) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= clamp_side(SIDE_RESET);
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         side_ff <= side_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   // Capture the transaction while its column word is read
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= sample;
         s1_col_ff    <= col_ff;
         s1_slot_ff   <= row_ff[LINE_BITS-1:0];
         s1_full_ff   <= (row_ff >= CNT_BITS'(LINES));
         s1_tag_ff    <= tag_s0;
      end
   end

   // One word per column holds that column of the last LINES rows
   swa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (MAX_SIDE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_col_ff),
      .wr_data (wr_word),
      .rd_addr (col_ff),
      .rd_data (rd_word)
   );

   // Sum the stored column, replace this row's slot with the new sample
   always_comb begin
      upper_sum = '0;
      wr_word   = rd_word;
      for (int i = 0; i < LINES; i++) begin
         upper_sum = upper_sum
                   + CSUM_BITS'($signed(rd_word[i*SAMPLE_BITS +: SAMPLE_BITS]));
         if (s1_slot_ff == LINE_BITS'(i)) begin
            wr_word[i*SAMPLE_BITS +: SAMPLE_BITS] = s1_sample_ff;
         end
      end
      csum = CSUM_BITS'($signed(s1_sample_ff)) + (s1_full_ff ? upper_sum : '0);
   end

   // Shift the column sums, newest at the top
   always_ff @(posedge clock) begin
      if (reset) begin
         col_sums_ff <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
         if (s1_valid_ff) begin
            col_sums_ff <= {csum, col_sums_ff[WINDOW-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         s2_tag_ff <= s1_tag_ff;
      end
   end

   assign sums_valid = s2_valid_ff;
   assign sums_tag   = s2_tag_ff;
   assign col_sums   = col_sums_ff;

   // The write-back never lands on the column being read
   a_no_ram_collision : assert property (@(posedge clock) disable iff (reset)
      (accept && s1_valid_ff) |-> (col_ff != s1_col_ff))
      else $error("line store write and read hit the same column");

endmodule

// File: rtl/swa_mean.sv
// Window mean: total of the column sums, then rounded divide by the window area.
// Depends on swa_pkg.
`timescale 1ns / 1ps

module swa_mean (
   input  logic                                         clock,
   input  logic                                         reset,
   input  logic                                         in_valid,
   input  swa_pkg::tag_type                             in_tag,
   input  logic [swa_pkg::WINDOW-1:0][swa_pkg::CSUM_BITS-1:0] col_sums,
   output logic                                         out_valid,
   output swa_pkg::tag_type                             out_tag,
   output logic [swa_pkg::SAMPLE_BITS-1:0]              out_mean
);

   import swa_pkg::*;

   logic signed [TOTAL_BITS-1:0] total_in, total_ff;
   logic                         t_valid_ff;
   tag_type                      t_tag_ff;

   logic [TOTAL_BITS-1:0]        abs_total;
   logic [MAG_BITS-1:0]          y_in, y_ff;
   logic                         m_neg_ff;
   logic                         m_valid_ff;
   tag_type                      m_tag_ff;

   logic [MAG_BITS+RECIP_BITS-1:0] prod;
   logic [QUOT_BITS-1:0]         q0_ff;
   logic [MAG_BITS-1:0]          p_y_ff;
   logic                         p_neg_ff;
   logic                         p_valid_ff;
   tag_type                      p_tag_ff;

   logic [MAG_BITS-1:0]          q_den, rem;
   logic [QUOT_BITS-1:0]         quot;
   logic [SAMPLE_BITS-1:0]       mean_in, mean_ff;
   logic                         out_valid_ff;
   tag_type                      out_tag_ff;

   // Add the window's column sums
   always_comb begin
      total_in = '0;
      for (int i = 0; i < WINDOW; i++) begin
         total_in = total_in + TOTAL_BITS'($signed(col_sums[i]));
      end
   end

   // Magnitude plus half the divisor
   assign abs_total = total_ff[TOTAL_BITS-1] ? (~total_ff + 1'b1) : total_ff;
   assign y_in      = MAG_BITS'(abs_total) + MAG_BITS'(HALF_DEN);

   // Quotient estimate, low by at most one
   assign prod = {{RECIP_BITS{1'b0}}, y_ff} * {{MAG_BITS{1'b0}}, RECIP_BITS'(RECIP)};

   // Correct the estimate and restore the sign
   always_comb begin
      q_den   = MAG_BITS'(q0_ff) * MAG_BITS'(DEN);
      rem     = p_y_ff - q_den;
      quot    = (rem >= MAG_BITS'(DEN)) ? q0_ff + 1'b1 : q0_ff;
      mean_in = p_neg_ff ? (~quot + 1'b1) : quot;
   end

   // Valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         t_valid_ff   <= 1'b0;
         m_valid_ff   <= 1'b0;
         p_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         t_valid_ff   <= in_valid;
         m_valid_ff   <= t_valid_ff;
         p_valid_ff   <= m_valid_ff;
         out_valid_ff <= p_valid_ff;
      end
   end

   // Payload stages
   always_ff @(posedge clock) begin
      total_ff   <= total_in;
      t_tag_ff   <= in_tag;
      y_ff       <= y_in;
      m_neg_ff   <= total_ff[TOTAL_BITS-1];
      m_tag_ff   <= t_tag_ff;
      q0_ff      <= QUOT_BITS'(prod >> RECIP_SHIFT);
      p_y_ff     <= y_ff;
      p_neg_ff   <= m_neg_ff;
      p_tag_ff   <= m_tag_ff;
      mean_ff    <= mean_in;
      out_tag_ff <= p_tag_ff;
   end

   assign out_valid = out_valid_ff;
   assign out_tag   = out_tag_ff;
   assign out_mean  = mean_ff;

   // Four stages (total, magnitude, estimate, mean), none of which stalls
   a_latency : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $past(in_valid, 4))
      else $error("mean pipeline produced a transaction out of step");

endmodule

// File: rtl/swa_rsp_fifo.sv
// Result queue: decouples the fixed-latency pipeline from the rsp channel stall.
// Depends on swa_pkg.
`timescale 1ns / 1ps

module swa_rsp_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  swa_pkg::rsp_type push_data,
   output logic             pop_valid,
   input  logic             pop_stall,
   output swa_pkg::rsp_type pop_data
);

   import swa_pkg::*;

   rsp_type                   slot_ff [RSP_DEPTH];
   logic [RSP_PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [RSP_COUNT_BITS-1:0] count_ff;
   logic                      pop;

   assign pop_valid = (count_ff != '0);
   assign pop       = pop_valid && !pop_stall;
   assign pop_data  = slot_ff[rd_ptr_ff];

   // Store incoming results
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + RSP_COUNT_BITS'(push) - RSP_COUNT_BITS'(pop);
      end
   end

   // Credit accounting upstream keeps the queue from overflowing
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> (count_ff != RSP_COUNT_BITS'(RSP_DEPTH)))
      else $error("result queue overflow");

endmodule

// File: rtl/sliding_window_average_pool.sv
// Channel  Direction  Ports                                        Transfer
// csr      in         csr_valid / csr_ready, csr_side_length       valid && ready
// req      in         req_valid / req_stall, req_sample            valid && !stall
// rsp      out        rsp_valid / rsp_stall, rsp_window_mean,      valid && !stall
//                     rsp_out_row, rsp_out_col, rsp_frame_end
//
// One sample per cycle sustained while req_stall is low; the line store is a single
// read/write RAM with one column word per cycle, read at acceptance and written back
// the next cycle. Results reach rsp_valid through the mean pipeline and result queue.
// req_stall rises when eight transactions are in the pipeline or waiting in the queue.
// Reset is synchronous; the line store is not cleared (rows are written before they
// are read in every frame).
//
// Top level of the 5x5 stride-1 average pool. Depends on swa_pkg, swa_front,
// swa_mean and swa_rsp_fifo.
`timescale 1ns / 1ps

module sliding_window_average_pool #(
   parameter int MAX_SIDE = swa_pkg::MAX_SIDE_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swa_pkg::SIDE_BITS-1:0]       csr_side_length,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic signed [swa_pkg::SAMPLE_BITS-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [swa_pkg::SAMPLE_BITS-1:0] rsp_window_mean,
   output logic [swa_pkg::POS_BITS-1:0]        rsp_out_row,
   output logic [swa_pkg::POS_BITS-1:0]        rsp_out_col,
   output logic                                rsp_frame_end
);

   import swa_pkg::*;

   logic                           accept, cfg_write;
   logic                           sums_valid;
   tag_type                        sums_tag;
   logic [WINDOW-1:0][CSUM_BITS-1:0] col_sums;
   logic                           mean_valid;
   tag_type                        mean_tag;
   logic [SAMPLE_BITS-1:0]         mean_value;
   logic                           push, drop, pop;
   rsp_type                        push_data, head;
   logic [RSP_COUNT_BITS-1:0]      occ_ff, occ_in;

   // Configuration is taken whenever offered
   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid && csr_ready;

   assign req_stall = (occ_ff == RSP_COUNT_BITS'(RSP_DEPTH));
   assign accept    = req_valid && !req_stall;

   swa_front #(
      .MAX_SIDE (MAX_SIDE)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg_write  (cfg_write),
      .cfg_side   (csr_side_length),
      .accept     (accept),
      .sample     (req_sample),
      .sums_valid (sums_valid),
      .sums_tag   (sums_tag),
      .col_sums   (col_sums)
   );

   swa_mean u_mean (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sums_valid),
      .in_tag    (sums_tag),
      .col_sums  (col_sums),
      .out_valid (mean_valid),
      .out_tag   (mean_tag),
      .out_mean  (mean_value)
   );

   // Queue windows that complete; drop the rest
   assign push = mean_valid && mean_tag.produce;
   assign drop = mean_valid && !mean_tag.produce;

   always_comb begin
      push_data.mean      = mean_value;
      push_data.row       = mean_tag.row;
      push_data.col       = mean_tag.col;
      push_data.frame_end = mean_tag.frame_end;
   end

   swa_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop_valid (rsp_valid),
      .pop_stall (rsp_stall),
      .pop_data  (head)
   );

   assign pop             = rsp_valid && !rsp_stall;
   assign rsp_window_mean = $signed(head.mean);
   assign rsp_out_row     = head.row;
   assign rsp_out_col     = head.col;
   assign rsp_frame_end   = head.frame_end;

   // Count transactions in flight or queued
   assign occ_in = occ_ff + RSP_COUNT_BITS'(accept) - RSP_COUNT_BITS'(pop)
                 - RSP_COUNT_BITS'(drop);

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   a_occ_bound : assert property (@(posedge clock) disable iff (reset)
      occ_ff <= RSP_COUNT_BITS'(RSP_DEPTH))
      else $error("transaction credit count exceeds queue depth");

   a_pop_has_credit : assert property (@(posedge clock) disable iff (reset)
      (pop || drop) |-> (occ_ff != '0))
      else $error("transaction retired with no credit outstanding");

endmodule

// File: verif/tb.sv
// Self-checking testbench for the 5x5 stride-1 sliding window average pool.
// Depends on swa_pkg and sliding_window_average_pool; predicts each window mean
// from its own line store and column sums and checks every result in order.
`timescale 1ns / 1ps

module tb;
   import swa_pkg::*;

   localparam int MAX_SIDE   = MAX_SIDE_DEFAULT;
   localparam int SETTLE     = 12;        // idle clocks after draining, before a side write or the finish
   localparam int HOLD_OFF   = 80;        // long receiver stall, well past queue depth
   localparam int RAND_ITEMS = 700;

   // Clock, reset and block ports
   logic                          clock           = 1'b0;
   logic                          reset           = 1'b1;
   logic                          csr_valid       = 1'b0;
   logic                          csr_ready;
   logic [SIDE_BITS-1:0]          csr_side_length = '0;
   logic                          req_valid       = 1'b0;
   logic                          req_stall;
   logic signed [SAMPLE_BITS-1:0] req_sample      = '0;
   logic                          rsp_valid;
   logic                          rsp_stall       = 1'b0;
   logic signed [SAMPLE_BITS-1:0] rsp_window_mean;
   logic [POS_BITS-1:0]           rsp_out_row;
   logic [POS_BITS-1:0]           rsp_out_col;
   logic                          rsp_frame_end;

   sliding_window_average_pool DUT (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_side_length (csr_side_length),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_window_mean (rsp_window_mean),
      .rsp_out_row     (rsp_out_row),
      .rsp_out_col     (rsp_out_col),
      .rsp_frame_end   (rsp_frame_end)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Shared control between stimulus, stall generator and checker
   rsp_type pending_means[$];
   int      mismatches    = 0;
   bit      calm          = 1'b0;     // no idling on either side while set
   int      hold_requests = 0;
   int      hold_served   = 0;
   int      hold_left     = 0;

   // Predictor state: configuration, counters, line store and column sums
   logic [SIDE_BITS-1:0]          pool_side = SIDE_RESET;
   int                            pool_row  = 0;
   int                            pool_col  = 0;
   logic signed [SAMPLE_BITS-1:0] line_buf [LINES][MAX_SIDE];
   longint                        col_sums [WINDOW];

   initial begin
      for (int r = 0; r < LINES; r++)
         for (int c = 0; c < MAX_SIDE; c++)
            line_buf[r][c] = '0;
      for (int i = 0; i < WINDOW; i++)
         col_sums[i] = 0;
   end

   // Clamp the configured side into WINDOW..MAX_SIDE
   function automatic int eff_side(input logic [SIDE_BITS-1:0] side);
      if (side < WINDOW)
         return WINDOW;
      if (side > MAX_SIDE)
         return MAX_SIDE;
      return int'(side);
   endfunction

   // Advance the window by one sample; return 1 when a full window closes
   function automatic bit predict_window(input logic signed [SAMPLE_BITS-1:0] smp,
                                         output rsp_type res);
      int     side;
      longint csum;
      longint total;
      longint mag;
      longint quot;
      bit     hit;
      side = eff_side(pool_side);
      csum = smp;
      total = 0;
      hit = 1'b0;
      res = '0;
      if (pool_row >= LINES)
         for (int i = 0; i < LINES; i++)
            csum += line_buf[i][pool_col];
      line_buf[pool_row % LINES][pool_col] = smp;
      for (int i = 0; i < WINDOW - 1; i++)
         col_sums[i] = col_sums[i + 1];
      col_sums[WINDOW - 1] = csum;
      if (pool_row >= LINES && pool_col >= LINES) begin
         for (int i = 0; i < WINDOW; i++)
            total += col_sums[i];
         // round half away from zero on the magnitude
         mag = (total < 0) ? -total : total;
         quot = (2 * mag + WINDOW * WINDOW) / (2 * WINDOW * WINDOW);
         if (total < 0)
            quot = -quot;
         res.mean      = quot[SAMPLE_BITS-1:0];
         res.row       = POS_BITS'(pool_row - LINES);
         res.col       = POS_BITS'(pool_col - LINES);
         res.frame_end = (pool_row == side - 1) && (pool_col == side - 1);
         hit = 1'b1;
      end
      pool_col++;
      if (pool_col >= side) begin
         pool_col = 0;
         pool_row++;
         if (pool_row >= side)
            pool_row = 0;
      end
      return hit;
   endfunction

   // Offer one sample, hold it until accepted, then record its expected mean
   task automatic offer_sample(input logic signed [SAMPLE_BITS-1:0] smp,
                               input bit typed, input rsp_type typed_exp);
      rsp_type res;
      while (!calm && $urandom_range(0, 99) < 7) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_sample <= smp;
      do @(posedge clock); while (req_stall);
      if (predict_window(smp, res))
         pending_means.insert(pending_means.size(), typed ? typed_exp : res);
   endtask

   // Drain the block, then write the side length; a write starts a new frame
   task automatic write_side(input logic [SIDE_BITS-1:0] side);
      req_valid <= 1'b0;
      while (pending_means.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      csr_valid       <= 1'b1;
      csr_side_length <= side;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      pool_side = side;
      pool_row  = 0;
      pool_col  = 0;
   endtask

   // Receiver stall: long hold-off on request, otherwise sparse random stalls
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = HOLD_OFF;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < 7);
      end
   end

   // Check each result transaction against the oldest expectation
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_means.size() == 0) begin
            $error("unexpected result: window_mean %0d out_row %0d out_col %0d frame_end %0d",
                   rsp_window_mean, rsp_out_row, rsp_out_col, rsp_frame_end);
            mismatches++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_window_mean !== want.mean) begin
               $error("window_mean: expected %0d, got %0d",
                      $signed(want.mean), rsp_window_mean);
               mismatches++;
            end
            if (rsp_out_row !== want.row) begin
               $error("out_row: expected %0d, got %0d", want.row, rsp_out_row);
               mismatches++;
            end
            if (rsp_out_col !== want.col) begin
               $error("out_col: expected %0d, got %0d", want.col, rsp_out_col);
               mismatches++;
            end
            if (rsp_frame_end !== want.frame_end) begin
               $error("frame_end: expected %0d, got %0d", want.frame_end, rsp_frame_end);
               mismatches++;
            end
         end
      end
   end

   // Directed frames: uniform fills, a single spot in the middle, alternating extremes
   typedef struct {
      bit                            set_side;
      logic [SIDE_BITS-1:0]          side;
      int                            count;
      logic signed [SAMPLE_BITS-1:0] fill;
      bit                            alternate;
      int                            spot_at;
      logic signed [SAMPLE_BITS-1:0] spot_val;
      bit                            typed;
      logic signed [SAMPLE_BITS-1:0] exp_mean;
      logic [POS_BITS-1:0]           exp_row;
      logic [POS_BITS-1:0]           exp_col;
      logic                          exp_end;
   } directed_row_type;

   localparam int DIR_ROWS = 7;

   directed_row_type dir_table [DIR_ROWS] = '{
      // side from reset: first window closes at row 4, column 4 of a 19-wide image
      '{1'b0, 6'd19, 81, 16'sd256,   1'b0, -1, 16'sd0,   1'b1, 16'sd256,   5'd0, 5'd0, 1'b0},
      // side below the window clamps to five; all maximum
      '{1'b1, 6'd0,  25, 16'sh7FFF,  1'b0, -1, 16'sd0,   1'b1, 16'sh7FFF,  5'd0, 5'd0, 1'b1},
      // all minimum
      '{1'b1, 6'd5,  25, 16'sh8000,  1'b0, -1, 16'sd0,   1'b1, 16'sh8000,  5'd0, 5'd0, 1'b1},
      // rounding: 13/25 goes up, 12/25 goes down, -13/25 goes away from zero
      '{1'b1, 6'd4,  25, 16'sd0,     1'b0, 12, 16'sd13,  1'b1, 16'sd1,     5'd0, 5'd0, 1'b1},
      '{1'b1, 6'd5,  25, 16'sd0,     1'b0, 12, 16'sd12,  1'b1, 16'sd0,     5'd0, 5'd0, 1'b1},
      '{1'b1, 6'd5,  25, 16'sd0,     1'b0, 12, -16'sd13, 1'b1, -16'sd1,    5'd0, 5'd0, 1'b1},
      // alternating extremes over a 6x6 frame
      '{1'b1, 6'd6,  36, 16'sh7FFF,  1'b1, -1, 16'sd0,   1'b0, 16'sd0,     5'd0, 5'd0, 1'b0}
   };

   localparam logic [SIDE_BITS-1:0] EARLY_SIDES [6] = '{6'd63, 6'd5, 6'd16, 6'd0, 6'd4, 6'd33};

   // Main stimulus
   initial begin
      rsp_type                       typed_exp;
      logic signed [SAMPLE_BITS-1:0] smp;
      logic [SIDE_BITS-1:0]          side;
      int                            s;
      int                            n;
      int                            sent;
      int                            phase;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed part
      foreach (dir_table[d]) begin
         if (dir_table[d].set_side)
            write_side(dir_table[d].side);
         typed_exp.mean      = dir_table[d].exp_mean;
         typed_exp.row       = dir_table[d].exp_row;
         typed_exp.col       = dir_table[d].exp_col;
         typed_exp.frame_end = dir_table[d].exp_end;
         for (int k = 0; k < dir_table[d].count; k++) begin
            smp = dir_table[d].fill;
            if (dir_table[d].alternate && k[0])
               smp = ~smp;
            if (k == dir_table[d].spot_at)
               smp = dir_table[d].spot_val;
            offer_sample(smp, dir_table[d].typed, typed_exp);
         end
      end

      // Random part: one side per phase, extremes first, mostly small sides later
      sent  = 0;
      phase = 0;
      while (sent < RAND_ITEMS || phase < 6) begin
         if (phase < 6)
            side = EARLY_SIDES[phase];
         else if ($urandom_range(0, 9) < 8)
            side = SIDE_BITS'($urandom_range(5, 12));
         else
            side = SIDE_BITS'($urandom_range(0, 63));
         write_side(side);
         s = eff_side(side);
         if (phase == 2)
            n = s * s + $urandom_range(20, 60);             // one full frame and a wrap
         else if (s > 12)
            n = $urandom_range(5 * s, 7 * s);
         else
            n = s * s * $urandom_range(1, 3) + $urandom_range(0, s * s - 1);
         calm = (phase == 0);
         if (phase == 2 || phase == 7)
            hold_requests++;
         for (int k = 0; k < n; k++) begin
            case ($urandom_range(0, 9))
               0:       smp = 16'sh7FFF;
               1:       smp = 16'sh8000;
               2, 3:    smp = SAMPLE_BITS'($signed($urandom_range(0, 600)) - 300);
               default: smp = SAMPLE_BITS'($urandom);
            endcase
            offer_sample(smp, 1'b0, typed_exp);
         end
         calm = 1'b0;
         sent += n;
         phase++;
      end

      // Drain and finish
      req_valid <= 1'b0;
      while (pending_means.size() != 0)
         @(posedge clock);
      repeat (SETTLE + 8) @(posedge clock);
      if (mismatches == 0 && pending_means.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
